/* hdl/irdl_pkg.sv */
// Shared types and calibration tables for the IR distance linearizer.
`timescale 1ns / 1ps
package irdl_pkg;

  localparam int NUM_BP  = 11;
  localparam int NUM_SEG = NUM_BP - 1;

  localparam int SAMPLE_W = 10;
  localparam int CM_W     = 7;
  localparam int OFFS_W   = 6;
  localparam int DIST_W   = 8;
  localparam int SEG_W    = 4;
  localparam int SCALE_W  = 5;
  localparam int DSR_W    = 9;
  localparam int DVD_W    = 12;
  localparam int QUO_W    = 5;
  localparam int QCNT_W   = 3;

  localparam logic [SEG_W-1:0]  LAST_SEG   = SEG_W'(NUM_SEG - 1);
  localparam logic [OFFS_W-1:0] OFFS_RESET = OFFS_W'(6);

  // Breakpoints in converter counts, nearest first
  localparam logic [SAMPLE_W-1:0] BP_COUNTS [NUM_BP] = '{
    10'd987, 10'd641, 10'd553, 10'd482, 10'd415, 10'd377,
    10'd330, 10'd268, 10'd220, 10'd182, 10'd125
  };
  localparam logic [CM_W-1:0] BP_CM [NUM_BP] = '{
    7'd0, 7'd7, 7'd10, 7'd13, 7'd17, 7'd20, 7'd24, 7'd32, 7'd41, 7'd50, 7'd80
  };
  localparam logic [SCALE_W-1:0] SEG_SCALE [NUM_SEG] = '{
    5'd7, 5'd4, 5'd4, 5'd5, 5'd4, 5'd5, 5'd9, 5'd9, 5'd9, 5'd31
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_DIV,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic            done;
    logic [CM_W-1:0] cm;
    logic            flag;
  } seq_res_t;

endpackage

/* hdl/irdl_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module irdl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  irdl_pkg::div_req_t req,
  output irdl_pkg::div_rsp_t rsp
);
  import irdl_pkg::*;

  localparam int TRIAL_W = DSR_W + QUO_W;

  logic [DVD_W-1:0]   rem_r, rem_nxt;
  logic [DSR_W-1:0]   dsr_r, dsr_nxt;
  logic [QUO_W-1:0]   q_r, q_nxt;
  logic [QCNT_W-1:0]  k_r, k_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [TRIAL_W-1:0] trial;
  logic               ge;

  // quotient is known to fit QUO_W bits, so the divisor starts shifted up
  assign trial = {{QUO_W{1'b0}}, dsr_r} << k_r;
  assign ge    = {{(TRIAL_W-DVD_W){1'b0}}, rem_r} >= trial;

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      q_nxt    = '0;
      k_nxt    = QCNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[QUO_W-2:0], ge};
      if (ge) begin
        rem_nxt = rem_r - trial[DVD_W-1:0];
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    k_r   <= k_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

/* hdl/irdl_seq.sv */
// Sequencer: segment search, scale multiply and divider control.
`timescale 1ns / 1ps
module irdl_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [irdl_pkg::SAMPLE_W-1:0] avg,
  output logic                          busy,
  output irdl_pkg::seq_res_t            res
);
  import irdl_pkg::*;

  localparam int PROD_W = DSR_W + SCALE_W;

  seq_state_t          state_r, state_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [SEG_W-1:0]    seg_r, seg_nxt;
  logic [SEG_W-1:0]    seg_up;
  logic [CM_W-1:0]     cm_r, cm_nxt;
  logic                flag_r, flag_nxt;
  logic [SAMPLE_W-1:0] lo, hi;
  logic [DSR_W-1:0]    span;
  logic [DSR_W-1:0]    delta;
  logic [PROD_W-1:0]   prod;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign seg_up = seg_r + SEG_W'(1);
  assign lo     = BP_COUNTS[seg_up];
  assign hi     = BP_COUNTS[seg_r];
  assign span   = DSR_W'(hi - lo);
  assign delta  = DSR_W'(avg_r - lo);
  assign prod   = {{SCALE_W{1'b0}}, delta} * {{DSR_W{1'b0}}, SEG_SCALE[seg_r]};

  irdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    avg_r  <= avg_nxt;
    seg_r  <= seg_nxt;
    cm_r   <= cm_nxt;
    flag_r <= flag_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    avg_nxt          = avg_r;
    seg_nxt          = seg_r;
    cm_nxt           = cm_r;
    flag_nxt         = flag_r;
    div_req.start    = 1'b0;
    div_req.dividend = prod[DVD_W-1:0];
    div_req.divisor  = span;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          avg_nxt = avg;
          seg_nxt = '0;
          if (avg > BP_COUNTS[0]) begin
            // above the near end: clamp to 0 cm
            cm_nxt    = BP_CM[0];
            flag_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (avg_r >= lo) begin
          state_nxt = S_MUL;
        end else if (seg_r == LAST_SEG) begin
          // below the far end: clamp to 80 cm
          cm_nxt    = BP_CM[NUM_BP-1];
          flag_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          seg_nxt = seg_up;
        end
      end
      S_MUL: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          cm_nxt    = BP_CM[seg_up] - CM_W'(div_rsp.quotient);
          flag_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy     = (state_r != S_IDLE);
  assign res.done = (state_r == S_DONE);
  assign res.cm   = cm_r;
  assign res.flag = flag_r;

endmodule

/* hdl/ir_distance_linearizer.sv */
// Top level of the IR distance linearizer: pairing, offset register, result register.
`timescale 1ns / 1ps
// IR range sensor linearizer. Raw 10-bit converter samples come in on the in_
// channel; every two samples are averaged (truncating) and the average is mapped
// to centimetres by piecewise-linear interpolation over eleven fixed calibration
// breakpoints (987 counts = 0 cm down to 125 counts = 80 cm). The bumper offset
// (cfg_ register, reset 6 cm) is then added. One request comes out on the out_
// channel for every second sample. A reading sitting exactly on a breakpoint
// gives that breakpoint's distance; readings beyond either end clamp to 0 or
// 80 cm before the offset and raise out_of_range. The first sample of a pair
// is held in a register. The second sample starts a sequencer that walks the
// segments one per cycle, works the scale multiply, runs the one-bit-per-cycle
// divider and hands the result off to the output register. A reading above
// the near end skips straight to the hand-off; one below the far end walks all
// ten segments and skips the divide. in_stall is high while the sequencer
// runs, and for a second sample while the previous result is still stalled.
// The offset register takes writes at any time (cfg_ready is tied high); write
// it only while the block is idle.
module ir_distance_linearizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [irdl_pkg::SAMPLE_W-1:0] in_adc_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [irdl_pkg::DIST_W-1:0]   out_distance_cm,
  output logic                          out_out_of_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [irdl_pkg::OFFS_W-1:0]   cfg_bumper_offset_cm
);
  import irdl_pkg::*;

  logic [OFFS_W-1:0]   offs_r;
  logic [SAMPLE_W-1:0] held_r;
  logic                have_first_r;
  logic                out_valid_r;
  logic [DIST_W-1:0]   dist_r;
  logic                oor_r;
  logic                in_acc;
  logic                seq_start;
  logic                seq_busy;
  logic [SAMPLE_W:0]   pair_sum;
  logic [SAMPLE_W-1:0] avg;
  seq_res_t            seq_res;

  // offset register always writable
  assign cfg_ready = 1'b1;

  // second sample must wait until the result slot will be free
  assign in_stall  = seq_busy | (have_first_r & out_valid_r & out_stall);
  assign in_acc    = in_valid & ~in_stall;
  assign seq_start = in_acc & have_first_r;

  assign pair_sum = {1'b0, held_r} + {1'b0, in_adc_sample};
  assign avg      = pair_sum[SAMPLE_W:1];

  irdl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seq_start),
    .avg   (avg),
    .busy  (seq_busy),
    .res   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offs_r       <= OFFS_RESET;
      have_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        offs_r <= cfg_bumper_offset_cm;
      end
      if (in_acc) begin
        have_first_r <= ~have_first_r;
      end
      if (seq_res.done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc && !have_first_r) begin
      held_r <= in_adc_sample;
    end
    if (seq_res.done) begin
      dist_r <= {1'b0, seq_res.cm} + {{(DIST_W-OFFS_W){1'b0}}, offs_r};
      oor_r  <= seq_res.flag;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_distance_cm  = dist_r;
  assign out_out_of_range = oor_r;

endmodule
